// ----- hdl/smnp_pkg.sv -----
// Shared types, constants and helper functions for the strobed nibble mouse port.
// No dependencies; every other file of the block imports this package.
package smnp_pkg;

	localparam int ACCUM_BITS_DEFAULT = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_RESOLUTION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE = 2'd2;

	localparam logic [15:0] RESOLUTION_RESET = 16'd400;
	localparam logic [15:0] TIMEOUT_RESET = 16'd300;
	localparam logic [15:0] GAP_MAX = 16'hffff;

	localparam int SCALE_FACTOR = 200;
	localparam int BYTE_MAX = 127;
	localparam int BYTE_MIN_MAG = 128;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_RISE = 2'd1,
		OP_FALL = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	typedef struct packed {
		op_t op;
		logic signed [7:0] delta_x;
		logic signed [7:0] delta_y;
		logic left_button;
		logic right_button;
	} cmd_t;

	typedef struct packed {
		logic [15:0] resolution_dpi;
		logic [15:0] timeout_ticks;
		logic reverse_nibble;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_X,
		ST_DIV_Y
	} state_t;

	// Nibble sent at a given position of the frame, high nibble first.
	function automatic logic [3:0] nibble_of(input logic [15:0] word, input logic [1:0] pos);
		logic [3:0] n;
		case (pos)
			2'd0: n = word[15:12];
			2'd1: n = word[11:8];
			2'd2: n = word[7:4];
			2'd3: n = word[3:0];
			default: n = word[3:0];
		endcase
		return n;
	endfunction

	function automatic logic [3:0] flip4(input logic [3:0] n);
		return {n[0], n[1], n[2], n[3]};
	endfunction

endpackage

// ----- hdl/smnp_front.sv -----
// Front part: accepts input items, classifies them into commands and holds
// them in a two-entry queue for the back part. Depends on smnp_pkg.
module smnp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] kind,
	input logic signed [7:0] delta_x,
	input logic signed [7:0] delta_y,
	input logic left_button,
	input logic right_button,
	output logic cmd_valid,
	output smnp_pkg::cmd_t cmd,
	input logic cmd_pop
);
	import smnp_pkg::*;

	cmd_t q_mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	cmd_t cmd_in;

	always_comb begin
		cmd_in.delta_x = delta_x;
		cmd_in.delta_y = delta_y;
		cmd_in.left_button = left_button;
		cmd_in.right_button = right_button;
		case (kind)
			OP_TICK: cmd_in.op = OP_TICK;
			OP_RISE: cmd_in.op = OP_RISE;
			OP_FALL: cmd_in.op = OP_FALL;
			default: cmd_in.op = OP_REPORT;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count out of range");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty queue");
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count did not grow on transfer");

endmodule

// ----- hdl/smnp_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on smnp_pkg for the default dividend width and the shared import convention.
module smnp_div #(
	parameter int NUM_W = smnp_pkg::ACCUM_BITS_DEFAULT + 8
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NUM_W-1:0] num,
	input logic [15:0] den,
	output logic busy,
	output logic done,
	output logic [NUM_W-1:0] quot
);
	import smnp_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [16:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [15:0] den_q;
	logic [16:0] shifted;
	logic fits;

	assign shifted = {rem_q[15:0], quo_q[NUM_W-1]};
	assign fits = (shifted >= {1'b0, den_q});

	// The dividend shifts out of the top of quo_q while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < CNT_W'(NUM_W)) else $error("divider step count overrun");

endmodule

// ----- hdl/smnp_back.sv -----
// Back part: executes queued commands, keeps accumulators, frame word, nibble
// sequence and edge timing, and holds the output register. Uses smnp_div, smnp_pkg.
module smnp_back #(
	parameter int ACCUM_BITS = smnp_pkg::ACCUM_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input smnp_pkg::cfg_t cfg,
	input logic cmd_valid,
	input smnp_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] data_pins,
	output logic trigger_one,
	output logic trigger_two
);
	import smnp_pkg::*;

	localparam int N = ACCUM_BITS;
	localparam int NUM_W = ACCUM_BITS + 8;

	state_t state_q, state_d;

	logic signed [N-1:0] acc_x_q, acc_y_q;
	logic [15:0] frame_word_q;
	logic [1:0] pos_q;
	logic [15:0] gap_q;
	logic [3:0] pins_q;
	logic [1:0] trig_q;
	logic [7:0] byte_x_q;
	logic out_valid_q;
	logic [3:0] out_pins_q;
	logic [1:0] out_trig_q;

	logic out_free;
	logic out_load;
	logic [3:0] out_pins_d;
	logic [1:0] out_trig_d;
	logic acc_add, acc_clear, gap_inc, gap_clear;
	logic pos_we, byte_x_we, fw_we;
	logic [1:0] pos_d, pos_eff;
	logic [15:0] fw_d;
	logic div_start, div_use_y, div_busy, div_done;
	logic [NUM_W-1:0] div_num, div_quot;
	logic [15:0] div_den;
	logic signed [N-1:0] num_src, sign_src;
	logic [N-1:0] mag;
	logic result_neg;
	logic [7:0] scaled_byte;
	logic signed [N:0] sum_x, sum_y;

	function automatic logic [3:0] pin_level(input logic [3:0] n, input logic rev);
		return ~(rev ? flip4(n) : n);
	endfunction

	// Numerator is |acc| * 200; the sign of -acc is applied after the divide.
	assign num_src = div_use_y ? acc_y_q : acc_x_q;
	assign mag = num_src[N-1] ? (~num_src + 1'b1) : num_src;
	assign div_num = NUM_W'(mag) * NUM_W'(SCALE_FACTOR);
	assign div_den = (cfg.resolution_dpi == 16'd0) ? 16'd1 : cfg.resolution_dpi;

	assign sign_src = (state_q == ST_DIV_Y) ? acc_y_q : acc_x_q;
	assign result_neg = !sign_src[N-1] && (sign_src != '0);

	always_comb begin
		if (result_neg) begin
			scaled_byte = (div_quot > NUM_W'(BYTE_MIN_MAG)) ? 8'h80
				: (~div_quot[7:0] + 8'd1);
		end else begin
			scaled_byte = (div_quot > NUM_W'(BYTE_MAX)) ? 8'h7f : div_quot[7:0];
		end
	end

	assign sum_x = (N+1)'(acc_x_q) + (N+1)'(cmd.delta_x);
	assign sum_y = (N+1)'(acc_y_q) + (N+1)'(cmd.delta_y);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		div_start = 1'b0;
		div_use_y = 1'b0;
		out_load = 1'b0;
		out_pins_d = pins_q;
		out_trig_d = trig_q;
		acc_add = 1'b0;
		acc_clear = 1'b0;
		gap_inc = 1'b0;
		gap_clear = 1'b0;
		pos_we = 1'b0;
		pos_d = pos_q;
		byte_x_we = 1'b0;
		fw_we = 1'b0;
		fw_d = {byte_x_q, scaled_byte};
		pos_eff = pos_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_TICK: begin
							gap_inc = 1'b1;
							out_load = 1'b1;
						end
						OP_REPORT: begin
							acc_add = 1'b1;
							out_trig_d = {cmd.right_button, cmd.left_button};
							out_load = 1'b1;
						end
						default: begin
							// A falling edge after a long enough gap restarts the frame.
							if (cmd.op == OP_FALL && gap_q >= cfg.timeout_ticks) begin
								pos_eff = 2'd0;
							end
							gap_clear = 1'b1;
							pos_we = 1'b1;
							if (pos_eff == 2'd0) begin
								pos_d = 2'd0;
								div_start = 1'b1;
								state_d = ST_DIV_X;
							end else begin
								pos_d = pos_eff + 2'd1;
								out_pins_d = pin_level(nibble_of(frame_word_q, pos_eff),
									cfg.reverse_nibble);
								out_load = 1'b1;
							end
						end
					endcase
				end
			end
			ST_DIV_X: begin
				if (div_done) begin
					byte_x_we = 1'b1;
					div_start = 1'b1;
					div_use_y = 1'b1;
					state_d = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					fw_we = 1'b1;
					acc_clear = 1'b1;
					pos_we = 1'b1;
					pos_d = 2'd1;
					out_pins_d = pin_level(nibble_of(fw_d, 2'd0), cfg.reverse_nibble);
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			frame_word_q <= '0;
			pos_q <= 2'd0;
			gap_q <= '0;
			pins_q <= '0;
			trig_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_clear) begin
				acc_x_q <= '0;
				acc_y_q <= '0;
			end else if (acc_add) begin
				acc_x_q <= (sum_x[N] != sum_x[N-1]) ? {sum_x[N], {(N-1){~sum_x[N]}}}
					: sum_x[N-1:0];
				acc_y_q <= (sum_y[N] != sum_y[N-1]) ? {sum_y[N], {(N-1){~sum_y[N]}}}
					: sum_y[N-1:0];
			end
			if (fw_we) begin
				frame_word_q <= fw_d;
			end
			if (pos_we) begin
				pos_q <= pos_d;
			end
			if (gap_clear) begin
				gap_q <= '0;
			end else if (gap_inc && gap_q != GAP_MAX) begin
				gap_q <= gap_q + 16'd1;
			end
			if (out_load) begin
				pins_q <= out_pins_d;
				trig_q <= out_trig_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_x_we) begin
			byte_x_q <= scaled_byte;
		end
		if (out_load) begin
			out_pins_q <= out_pins_d;
			out_trig_q <= out_trig_d;
		end
	end

	smnp_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.done(div_done),
		.quot(div_quot)
	);

	assign out_valid = out_valid_q;
	assign data_pins = out_pins_q;
	assign trigger_one = out_trig_q[0];
	assign trigger_two = out_trig_q[1];

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("output register overwritten");
	a_div_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_X || state_q == ST_DIV_Y) |-> !out_valid_q)
		else $error("result pending during frame scaling");
	a_div_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV_X || state_q == ST_DIV_Y))
		else $error("divider running outside scaling states");
	a_no_pop_scaling: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd_pop) else $error("command taken during scaling");

endmodule

// ----- hdl/strobed_nibble_mouse_port.sv -----
// Top level of the strobed nibble mouse port: configuration registers and the
// front part with its queue and the back part. Uses smnp_pkg, smnp_front and smnp_back.
//
// Each input item (microsecond tick, strobe rising or falling edge, mouse
// report) produces exactly one result with the current data pin levels and
// trigger lines. Items enter a two-entry command queue; ticks, reports and
// edges within a frame pass through the queue and the output register, and
// the block can take one such item per cycle while out_ready stays high. The
// edge that starts a frame scales both axes on one shared bit-serial divider,
// one quotient bit per cycle, and no further command leaves the queue until
// both axes are scaled. Configuration writes take effect at once and are meant to
// be made while no item is in flight.
module strobed_nibble_mouse_port #(
	parameter int ACCUM_BITS = smnp_pkg::ACCUM_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [smnp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [smnp_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] kind,
	input logic signed [7:0] delta_x,
	input logic signed [7:0] delta_y,
	input logic left_button,
	input logic right_button,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] data_pins,
	output logic trigger_one,
	output logic trigger_two
);
	import smnp_pkg::*;

	cfg_t cfg_q;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resolution_dpi <= RESOLUTION_RESET;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
			cfg_q.reverse_nibble <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RESOLUTION: cfg_q.resolution_dpi <= cfg_data;
				CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				CFG_REVERSE: cfg_q.reverse_nibble <= cfg_data[0];
				default: ;
			endcase
		end
	end

	smnp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.delta_x(delta_x),
		.delta_y(delta_y),
		.left_button(left_button),
		.right_button(right_button),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	smnp_back #(
		.ACCUM_BITS(ACCUM_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_pins(data_pins),
		.trigger_one(trigger_one),
		.trigger_two(trigger_two)
	);

endmodule

// ----- tb/sv/smnp_checker.sv -----
// Checker for the strobed nibble mouse port: follows every transfer and register
// write, predicts the pin and trigger levels and compares each result with them.
// Depends on smnp_pkg for the command codes, register indexes and constants.
module smnp_checker #(
	parameter int ACCUM_BITS = smnp_pkg::ACCUM_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [smnp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [smnp_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] kind,
	input logic signed [7:0] delta_x,
	input logic signed [7:0] delta_y,
	input logic left_button,
	input logic right_button,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] data_pins,
	input logic trigger_one,
	input logic trigger_two,
	output int mismatches,
	output int levels_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import smnp_pkg::*;

	typedef struct packed {
		logic [3:0] pins;
		logic trig_one;
		logic trig_two;
	} port_levels_t;

	port_levels_t pending_levels[$];

	logic [15:0] dpi_q;
	logic [15:0] gap_limit_q;
	logic flip_q;
	logic signed [ACCUM_BITS-1:0] sum_x;
	logic signed [ACCUM_BITS-1:0] sum_y;
	logic [15:0] latched_word;
	logic [15:0] ticks_since_edge;
	logic [1:0] next_nibble;
	logic [3:0] pins_now;
	logic [1:0] triggers_now;

	function automatic logic signed [ACCUM_BITS-1:0] add_clamped(
			input logic signed [ACCUM_BITS-1:0] acc, input logic signed [7:0] delta);
		longint top_val;
		longint total;
		top_val = (longint'(1) <<< (ACCUM_BITS - 1)) - 1;
		total = longint'(acc) + longint'(delta);
		if (total > top_val) begin
			total = top_val;
		end else if (total < -top_val - 1) begin
			total = -top_val - 1;
		end
		return total[ACCUM_BITS-1:0];
	endfunction

	// The axis is negated and scaled, divided toward zero and clamped to a signed byte.
	function automatic logic [7:0] axis_byte(input logic signed [ACCUM_BITS-1:0] acc);
		longint divisor;
		longint v;
		divisor = dpi_q;
		if (divisor == 0) begin
			divisor = 1;
		end
		v = -longint'(acc) * SCALE_FACTOR / divisor;
		if (v > BYTE_MAX) begin
			v = BYTE_MAX;
		end else if (v < -BYTE_MIN_MAG) begin
			v = -BYTE_MIN_MAG;
		end
		return v[7:0];
	endfunction

	task automatic take_edge(input logic falling);
		logic [3:0] nib;
		logic [3:0] flipped;
		if (falling && ticks_since_edge >= gap_limit_q) begin
			next_nibble = 2'd0;
		end
		ticks_since_edge = '0;
		// The first nibble of a frame latches both axes and empties the sums.
		if (next_nibble == 2'd0) begin
			latched_word = {axis_byte(sum_x), axis_byte(sum_y)};
			sum_x = '0;
			sum_y = '0;
		end
		nib = latched_word[4 * (3 - int'(next_nibble)) +: 4];
		if (flip_q) begin
			for (int b = 0; b < 4; b++) begin
				flipped[b] = nib[3 - b];
			end
			nib = flipped;
		end
		pins_now = ~nib;
		next_nibble = next_nibble + 2'd1;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		port_levels_t want;
		if (!arst_n) begin
			dpi_q = RESOLUTION_RESET;
			gap_limit_q = TIMEOUT_RESET;
			flip_q = 1'b0;
			sum_x = '0;
			sum_y = '0;
			latched_word = '0;
			ticks_since_edge = '0;
			next_nibble = '0;
			pins_now = '0;
			triggers_now = '0;
			pending_levels.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RESOLUTION: dpi_q = cfg_data;
					CFG_TIMEOUT: gap_limit_q = cfg_data;
					CFG_REVERSE: flip_q = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_levels.size() == 0) begin
					$error("result transfer with no result expected: data_pins %0h", data_pins);
					mismatches++;
				end else begin
					want = pending_levels.pop_front();
					if (data_pins !== want.pins) begin
						$error("data_pins: expected %0h, actual %0h", want.pins, data_pins);
						mismatches++;
					end
					if (trigger_one !== want.trig_one) begin
						$error("trigger_one: expected %0b, actual %0b", want.trig_one,
							trigger_one);
						mismatches++;
					end
					if (trigger_two !== want.trig_two) begin
						$error("trigger_two: expected %0b, actual %0b", want.trig_two,
							trigger_two);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (op_t'(kind))
					OP_TICK: begin
						if (ticks_since_edge != GAP_MAX) begin
							ticks_since_edge++;
						end
					end
					OP_RISE: take_edge(1'b0);
					OP_FALL: take_edge(1'b1);
					OP_REPORT: begin
						triggers_now = {right_button, left_button};
						sum_x = add_clamped(sum_x, delta_x);
						sum_y = add_clamped(sum_y, delta_y);
					end
					default: ;
				endcase
				want.pins = pins_now;
				want.trig_one = triggers_now[0];
				want.trig_two = triggers_now[1];
				pending_levels.push_back(want);
			end
		end
		levels_owed = pending_levels.size();
	end

endmodule

// ----- tb/sv/tb_strobed_nibble_mouse_port.sv -----
// Testbench top for the strobed nibble mouse port: reset, register settings,
// directed and random stimulus under varying back-pressure, and the verdict.
// Depends on smnp_pkg, strobed_nibble_mouse_port and smnp_checker.
module tb_strobed_nibble_mouse_port;
	timeunit 1ns;
	timeprecision 1ps;
	import smnp_pkg::*;

	typedef enum int {
		PACE_FREE,
		PACE_SENDER,
		PACE_RECEIVER,
		PACE_BOTH
	} pace_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_RESOLUTION;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = OP_TICK;
	logic signed [7:0] delta_x = '0;
	logic signed [7:0] delta_y = '0;
	logic left_button = 1'b0;
	logic right_button = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] data_pins;
	logic trigger_one;
	logic trigger_two;

	int mismatches;
	int levels_owed;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int gap_limit = int'(TIMEOUT_RESET);

	strobed_nibble_mouse_port dut (.*);
	smnp_checker checker_i (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] pick_delta();
		case ($urandom_range(3))
			0: return 8'h7f;
			1: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic put_item(input op_t op, input logic [7:0] dx, input logic [7:0] dy,
			input logic lb, input logic rb);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind = op;
		delta_x = dx;
		delta_y = dy;
		left_button = lb;
		right_button = rb;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Fields that the operation does not use still carry random values.
	task automatic put_bare(input op_t op);
		put_item(op, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic put_frame();
		int lo;
		int hi;
		repeat ($urandom_range(5)) begin
			put_item(OP_REPORT, pick_delta(), pick_delta(), 1'($urandom), 1'($urandom));
		end
		// Wait out about a short restart gap, so a restart sometimes just misses.
		if (gap_limit <= 400) begin
			lo = (gap_limit == 0) ? 0 : gap_limit - 1;
			hi = gap_limit + 1;
		end else begin
			lo = 0;
			hi = 5;
		end
		repeat ($urandom_range(hi, lo)) put_bare(OP_TICK);
		for (int e = 0; e < 4; e++) begin
			if (e > 0) begin
				repeat ($urandom_range(2)) put_bare(OP_TICK);
			end
			put_bare((e % 2 == 0) ? OP_FALL : OP_RISE);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (levels_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(input int res, input int tmo, input logic rev, input pace_t pace,
			input int budget);
		int goal;
		settle();
		write_reg(CFG_RESOLUTION, 16'(res));
		write_reg(CFG_TIMEOUT, 16'(tmo));
		write_reg(CFG_REVERSE, {15'($urandom), rev});
		gap_limit = tmo;
		send_idle_pct = (pace == PACE_SENDER) ? 66 : (pace == PACE_BOTH) ? 20 : 0;
		recv_stall_pct = (pace == PACE_RECEIVER) ? 66 : (pace == PACE_BOTH) ? 20 : 0;
		goal = items_sent + budget;
		while (items_sent < goal) begin
			if ($urandom_range(99) < 15) begin
				put_bare(op_t'($urandom_range(3)));
			end else begin
				put_frame();
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Default settings: pins before any edge, extreme reports, frames and
		// reports or ticks in the middle of a frame.
		put_bare(OP_TICK);
		put_item(OP_REPORT, 8'h7f, 8'h80, 1'b1, 1'b0);
		put_item(OP_REPORT, 8'h80, 8'h7f, 1'b0, 1'b1);
		put_item(OP_REPORT, 8'h00, 8'h00, 1'b1, 1'b1);
		put_item(OP_REPORT, 8'h7f, 8'h7f, 1'b0, 1'b0);
		put_bare(OP_RISE);
		put_bare(OP_TICK);
		put_bare(OP_TICK);
		put_bare(OP_FALL);
		put_item(OP_REPORT, 8'h80, 8'h80, 1'b1, 1'b0);
		put_bare(OP_TICK);
		put_bare(OP_RISE);
		put_bare(OP_FALL);
		put_bare(OP_RISE);
		put_bare(OP_FALL);
		put_bare(OP_RISE);
		put_bare(OP_FALL);

		run_phase(1, 4, 1'b0, PACE_FREE, 150);
		run_phase(0, 1, 1'b1, PACE_SENDER, 150);
		run_phase(65535, 9, 1'b1, PACE_RECEIVER, 150);
		run_phase(400, 300, 1'b0, PACE_BOTH, 300);
		run_phase(173, 0, 1'b0, PACE_FREE, 120);
		run_phase($urandom_range(65535, 1), $urandom_range(40, 1), 1'($urandom), PACE_BOTH,
			120);
		run_phase(3000, 16, 1'b0, PACE_SENDER, 120);
		run_phase(2, 7, 1'b1, PACE_RECEIVER, 120);

		// Saturated sums: each block of reports drives one axis to its top and
		// the other to its bottom before a later frame latches them.
		run_phase(65535, 65535, 1'b0, PACE_FREE, 0);
		put_bare(OP_RISE);
		repeat (260) put_item(OP_REPORT, 8'h7f, 8'h80, 1'($urandom), 1'($urandom));
		put_bare(OP_FALL);
		repeat (3) put_bare(OP_RISE);
		repeat (260) put_item(OP_REPORT, 8'h80, 8'h7f, 1'($urandom), 1'($urandom));
		repeat (4) put_bare(OP_RISE);

		settle();
		repeat (60) @(negedge clk);
		if (mismatches == 0 && levels_owed == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
